[rtl/row_statistics_accumulator_macros.svh]
// Assertion macros for the row statistics accumulator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ROW_STATISTICS_ACCUMULATOR_MACROS_SVH
`define ROW_STATISTICS_ACCUMULATOR_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define RSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("row statistics check failed");

// Check that a condition never holds outside reset.
`define RSA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("row statistics forbidden condition");

`endif

[rtl/rsa_pkg.sv]
// Shared constants and types of the row statistics accumulator.
// No dependencies.
`timescale 1ns / 1ps
package rsa_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned MaxRow  = 4096;
  localparam int unsigned CountW  = 13;
  localparam int unsigned SumW    = 29;
  localparam int unsigned SqW     = 43;
  localparam int unsigned RangeW  = 17;
  localparam int unsigned StatW   = 24;
  localparam int unsigned DW      = 56;
  localparam int unsigned RootW   = 40;
  localparam int unsigned RemW    = 43;
  localparam int unsigned RadW    = 80;
  localparam int unsigned DivW    = 40;
  localparam int unsigned StepW   = 6;
  localparam int unsigned SqLoW   = 22;

  typedef struct packed {
    logic [CountW-1:0]         cnt;
    logic signed [SumW-1:0]    sum;
    logic [SqW-1:0]            sumsq;
    logic signed [SampleW-1:0] mn;
    logic signed [SampleW-1:0] mx;
    logic                      ovf;
  } row_rec_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkMul,
    BkDivMean,
    BkSqrt,
    BkDivStd,
    BkDone
  } bk_state_e;

endpackage

[rtl/row_statistics_accumulator.sv]
// Row statistics accumulator: per-row min, max, range, mean and std deviation.
// Usage: in channel (in_valid_i/in_ready_o) carries sample_i and end_of_row_i.
// A sample with end_of_row_i low joins the open row; a request with it high
// closes the row and yields one result on the out channel (out_valid_o /
// out_ready_i). Samples beyond the row limit are dropped and flagged.
// Throughput: one sample per cycle while in_ready_o is high. Row close is
// queued (two rows deep); the back end works through each nonempty row with
// the bit-serial divider and square root, overlapped with the next row's
// samples; an empty row skips them. in_ready_o drops only while both queue
// entries are taken.
// Reset clears the row state, the queue and the output valid.
// When the receiver stalls, the result holds in the output register; the back
// end stops, the queue fills and then in_ready_o falls.
// Depends on rsa_pkg, rsa_front, rsa_fifo, rsa_back and the macro header.
`timescale 1ns / 1ps
`include "row_statistics_accumulator_macros.svh"
module row_statistics_accumulator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [rsa_pkg::SampleW-1:0]  sample_i,
  input  logic                                end_of_row_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rsa_pkg::SampleW-1:0]  row_min_o,
  output logic signed [rsa_pkg::SampleW-1:0]  row_max_o,
  output logic signed [rsa_pkg::RangeW-1:0]   row_range_o,
  output logic signed [rsa_pkg::StatW-1:0]    row_mean_o,
  output logic signed [rsa_pkg::StatW-1:0]    row_stddev_o,
  output logic [rsa_pkg::CountW-1:0]          sample_count_o,
  output logic                                overflowed_o
);
  import rsa_pkg::*;

  logic     acc, push, full, fvalid, pop;
  row_rec_t rec_in, rec_out;

  assign in_ready_o = !full;
  assign acc        = in_valid_i && in_ready_o;

  rsa_front u_front (
    .clk_i, .rst_ni, .acc_i(acc), .sample_i, .end_of_row_i,
    .push_o(push), .rec_o(rec_in)
  );

  rsa_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .rec_i(rec_in), .full_o(full),
    .valid_o(fvalid), .pop_i(pop), .rec_o(rec_out)
  );

  rsa_back u_back (
    .clk_i, .rst_ni, .valid_i(fvalid), .rec_i(rec_out), .pop_o(pop),
    .out_valid_o, .out_ready_i, .row_min_o, .row_max_o, .row_range_o,
    .row_mean_o, .row_stddev_o, .sample_count_o, .overflowed_o
  );

  `RSA_ASSERT_IMP(a_min_le_max, out_valid_o && sample_count_o != '0, row_min_o <= row_max_o)
  `RSA_ASSERT_IMP(a_empty_mean, out_valid_o && sample_count_o == '0, row_mean_o == -StatW'(256))
  `RSA_ASSERT_NEVER(a_count_limit, out_valid_o && sample_count_o > CountW'(MaxRow))
  `RSA_ASSERT_NEVER(a_pop_empty, pop && !fvalid)

endmodule

[rtl/rsa_front.sv]
// Front end: accepts samples, keeps the running row statistics.
// Depends on rsa_pkg; pushes one row request per end-of-row marker.
`timescale 1ns / 1ps
module rsa_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              acc_i,
  input  logic signed [rsa_pkg::SampleW-1:0] sample_i,
  input  logic                              end_of_row_i,
  output logic                              push_o,
  output rsa_pkg::row_rec_t                 rec_o
);
  import rsa_pkg::*;

  logic [CountW-1:0]         cnt_q, cnt_d;
  logic signed [SumW-1:0]    sum_q, sum_d;
  logic [SqW-1:0]            sq_q, sq_d;
  logic signed [SampleW-1:0] mn_q, mn_d, mx_q, mx_d;
  logic                      ovf_q, ovf_d;
  logic signed [SampleW:0]   sx;
  logic [SampleW:0]          mag;

  always_comb begin
    sx    = {sample_i[SampleW-1], sample_i};
    mag   = sx[SampleW] ? (SampleW+1)'(0) - sx : sx;
    cnt_d = cnt_q;
    sum_d = sum_q;
    sq_d  = sq_q;
    mn_d  = mn_q;
    mx_d  = mx_q;
    ovf_d = ovf_q;
    if (acc_i) begin
      if (end_of_row_i) begin
        cnt_d = '0;
        sum_d = '0;
        sq_d  = '0;
        mn_d  = '0;
        mx_d  = '0;
        ovf_d = 1'b0;
      end else if (cnt_q >= CountW'(MaxRow)) begin
        ovf_d = 1'b1;
      end else begin
        if (cnt_q == '0 || sample_i < mn_q) mn_d = sample_i;
        if (cnt_q == '0 || sample_i > mx_q) mx_d = sample_i;
        sum_d = sum_q + SumW'(sample_i);
        sq_d  = sq_q + SqW'(mag * mag);
        cnt_d = cnt_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
      mn_q  <= '0;
      mx_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      sq_q  <= sq_d;
      mn_q  <= mn_d;
      mx_q  <= mx_d;
      ovf_q <= ovf_d;
    end
  end

  assign push_o = acc_i && end_of_row_i;
  assign rec_o  = '{cnt: cnt_q, sum: sum_q, sumsq: sq_q, mn: mn_q, mx: mx_q, ovf: ovf_q};

endmodule

[rtl/rsa_fifo.sv]
// Two-entry queue of finished row requests between front and back end.
// Depends on rsa_pkg.
`timescale 1ns / 1ps
module rsa_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rsa_pkg::row_rec_t rec_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output rsa_pkg::row_rec_t rec_o
);
  import rsa_pkg::*;

  row_rec_t   mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] fill_q, fill_d;

  always_comb begin
    wr_d   = wr_q ^ push_i;
    rd_d   = rd_q ^ pop_i;
    fill_d = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign rec_o   = mem_q[rd_q];

endmodule

[rtl/rsa_back.sv]
// Back end: per-row multiply, shared restoring divider and digit-by-digit
// square root, then the output register. Depends on rsa_pkg.
`timescale 1ns / 1ps
module rsa_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  rsa_pkg::row_rec_t                   rec_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rsa_pkg::SampleW-1:0]  row_min_o,
  output logic signed [rsa_pkg::SampleW-1:0]  row_max_o,
  output logic signed [rsa_pkg::RangeW-1:0]   row_range_o,
  output logic signed [rsa_pkg::StatW-1:0]    row_mean_o,
  output logic signed [rsa_pkg::StatW-1:0]    row_stddev_o,
  output logic [rsa_pkg::CountW-1:0]          sample_count_o,
  output logic                                overflowed_o
);
  import rsa_pkg::*;

  bk_state_e          state_q, state_d;
  logic [StepW-1:0]   step_q;
  row_rec_t           rec_q;
  logic [SumW-2:0]    smag;
  logic [DW-1:0]      lo_q, hi_q, ssq_q, d_q;
  logic [DivW-1:0]    dvd_q, q_nxt;
  logic [CountW-1:0]  drem_q, drem_nxt;
  logic [CountW:0]    dr;
  logic               dge;
  logic [RadW-1:0]    rad_q;
  logic [RemW-1:0]    srem_q, srem2, trial, srem_nxt;
  logic [RootW-1:0]   root_q, root_nxt;
  logic               sge;
  logic signed [StatW-1:0] mean_q, mean_nxt;
  logic               out_valid_q;
  logic               last_step;
  logic               load_out;

  always_comb begin
    smag     = (SumW-1)'(rec_q.sum[SumW-1] ? -rec_q.sum : rec_q.sum);
    dr       = {drem_q, dvd_q[DivW-1]};
    dge      = dr >= {1'b0, rec_q.cnt};
    drem_nxt = CountW'(dge ? dr - {1'b0, rec_q.cnt} : dr);
    q_nxt    = {dvd_q[DivW-2:0], dge};
    mean_nxt = rec_q.sum[SumW-1] ?
               StatW'(-$signed({1'b0, q_nxt}) - $signed({1'b0, drem_nxt != '0})) :
               StatW'(q_nxt);
    srem2    = {srem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
    trial    = RemW'({root_q, 2'b01});
    sge      = srem2 >= trial;
    srem_nxt = sge ? srem2 - trial : srem2;
    root_nxt = {root_q[RootW-2:0], sge};
    last_step = step_q == StepW'(DivW - 1);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle:    if (valid_i) state_d = (rec_i.cnt == '0) ? BkDone : BkMul;
      BkMul:     if (step_q == StepW'(3)) state_d = BkDivMean;
      BkDivMean: if (last_step) state_d = BkSqrt;
      BkSqrt:    if (step_q == StepW'(RootW - 1)) state_d = BkDivStd;
      BkDivStd:  if (last_step) state_d = BkDone;
      BkDone:    if (!out_valid_q || out_ready_i) state_d = BkIdle;
      default:   state_d = BkIdle;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == BkIdle) && valid_i;
    load_out = (state_q == BkDone) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= (state_d != state_q) ? '0 : step_q + 1'b1;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BkIdle: if (valid_i) rec_q <= rec_i;
      BkMul: begin
        case (step_q)
          StepW'(0): lo_q  <= DW'(rec_q.cnt * rec_q.sumsq[SqLoW-1:0]);
          StepW'(1): hi_q  <= DW'(rec_q.cnt * rec_q.sumsq[SqW-1:SqLoW]);
          StepW'(2): ssq_q <= DW'(smag * smag);
          default: begin
            d_q    <= (hi_q << SqLoW) + lo_q - ssq_q;
            dvd_q  <= DivW'({smag, 8'b0});
            drem_q <= '0;
          end
        endcase
      end
      BkDivMean: begin
        dvd_q  <= q_nxt;
        drem_q <= drem_nxt;
        if (last_step) begin
          mean_q <= mean_nxt;
          rad_q  <= {(RadW - DW - 16)'(0), d_q, 16'b0};
          srem_q <= '0;
          root_q <= '0;
        end
      end
      BkSqrt: begin
        rad_q  <= rad_q << 2;
        srem_q <= srem_nxt;
        root_q <= root_nxt;
        if (step_q == StepW'(RootW - 1)) begin
          dvd_q  <= DivW'(root_nxt);
          drem_q <= '0;
        end
      end
      BkDivStd: begin
        dvd_q  <= q_nxt;
        drem_q <= drem_nxt;
      end
      BkDone: begin
        if (load_out) begin
          sample_count_o <= rec_q.cnt;
          overflowed_o   <= rec_q.ovf;
          if (rec_q.cnt == '0) begin
            row_min_o    <= '1;
            row_max_o    <= '1;
            row_range_o  <= '1;
            row_mean_o   <= -StatW'(256);
            row_stddev_o <= -StatW'(256);
          end else begin
            row_min_o    <= rec_q.mn;
            row_max_o    <= rec_q.mx;
            row_range_o  <= RangeW'(rec_q.mx) - RangeW'(rec_q.mn);
            row_mean_o   <= mean_q;
            row_stddev_o <= StatW'(dvd_q);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[sim/tb.sv]
// Testbench for row_statistics_accumulator: streams sample rows, predicts the
// per-row min, max, range, mean and std deviation, and checks every result.
// Depends on rsa_pkg and the accumulator RTL.
`timescale 1ns / 1ps
module tb;
  import rsa_pkg::*;

  typedef struct {
    logic signed [SampleW-1:0] sample;
    logic                      eor;
    bit                        drain;
  } request_t;

  typedef struct {
    logic signed [SampleW-1:0] mn;
    logic signed [SampleW-1:0] mx;
    logic signed [RangeW-1:0]  range;
    logic signed [StatW-1:0]   mean;
    logic signed [StatW-1:0]   stddev;
    logic [CountW-1:0]         cnt;
    logic                      ovf;
  } row_stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SampleW-1:0] sample_i = '0;
  logic end_of_row_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SampleW-1:0] row_min_o, row_max_o;
  logic signed [RangeW-1:0] row_range_o;
  logic signed [StatW-1:0] row_mean_o, row_stddev_o;
  logic [CountW-1:0] sample_count_o;
  logic overflowed_o;

  request_t   pending_q[$];
  row_stats_t row_stats_q[$];
  int n_total, n_sent, n_fail;
  int in_gap, out_gap;

  longint          acc_cnt, acc_sum, acc_min, acc_max;
  longint unsigned acc_sq;
  bit              acc_ovf;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  row_statistics_accumulator DUT (.*);

  function automatic logic [39:0] root_of(logic [79:0] v);
    logic [39:0] r, cand;
    logic [79:0] sq;
    r = '0;
    for (int b = 39; b >= 0; b--) begin
      cand = r | (40'd1 << b);
      sq = {40'd0, cand} * {40'd0, cand};
      if (sq <= v) r = cand;
    end
    return r;
  endfunction

  task automatic fold_request(request_t rq);
    longint s, a, q;
    longint unsigned d;
    row_stats_t e;
    s = rq.sample;
    if (!rq.eor) begin
      if (acc_cnt >= MaxRow) acc_ovf = 1'b1;
      else begin
        if (acc_cnt == 0 || s < acc_min) acc_min = s;
        if (acc_cnt == 0 || s > acc_max) acc_max = s;
        acc_sum += s;
        acc_sq += longint'(s * s);
        acc_cnt++;
      end
      return;
    end
    if (acc_cnt == 0) begin
      e = '{-16'sd1, -16'sd1, -17'sd1, -24'sd256, -24'sd256, '0, 1'b0};
    end else begin
      a = acc_sum * 256;
      q = a / acc_cnt;
      if (a % acc_cnt != 0 && a < 0) q--;
      d = longint'(acc_cnt) * acc_sq - longint'(acc_sum * acc_sum);
      e.mn = SampleW'(acc_min);
      e.mx = SampleW'(acc_max);
      e.range = RangeW'(acc_max - acc_min);
      e.mean = StatW'(q);
      e.stddev = StatW'(64'(root_of({d[63:0], 16'd0})) / acc_cnt);
      e.cnt = CountW'(acc_cnt);
      e.ovf = acc_ovf;
    end
    row_stats_q.push_back(e);
    acc_cnt = 0; acc_sum = 0; acc_sq = 0; acc_min = 0; acc_max = 0; acc_ovf = 0;
  endtask

  function automatic bit quiet_tail();
    return n_sent > n_total - 150;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        fold_request('{sample_i, end_of_row_i, 1'b0});
        n_sent++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() == 0 ||
                     (pending_q[0].drain && row_stats_q.size() != 0)) begin
          in_valid_i <= 1'b0;
        end else begin
          request_t rq;
          rq = pending_q.pop_front();
          sample_i <= rq.sample;
          end_of_row_i <= rq.eor;
          in_valid_i <= 1'b1;
          if (!quiet_tail() && $urandom_range(0, 19) == 0) in_gap <= $urandom_range(1, 9);
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (row_stats_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected result, min %0d", row_min_o);
        end else begin
          row_stats_t e;
          e = row_stats_q.pop_front();
          if (e.mn !== row_min_o || e.mx !== row_max_o || e.range !== row_range_o ||
              e.mean !== row_mean_o || e.stddev !== row_stddev_o ||
              e.cnt !== sample_count_o || e.ovf !== overflowed_o) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch exp %0d %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d %0d",
                       e.mn, e.mx, e.range, e.mean, e.stddev, e.cnt, e.ovf,
                       row_min_o, row_max_o, row_range_o, row_mean_o, row_stddev_o,
                       sample_count_o, overflowed_o);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet_tail() && $urandom_range(0, 7) == 0) out_gap <= $urandom_range(1, 9);
      end
    end
  end

  task automatic add_sample(logic signed [SampleW-1:0] s);
    pending_q.push_back('{s, 1'b0, 1'b0});
  endtask

  task automatic add_row_end(bit drain);
    pending_q.push_back('{SampleW'($urandom), 1'b1, drain});
  endtask

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return SampleW'($urandom_range(0, 20) - 10);
      default: return SampleW'($urandom);
    endcase
  endfunction

  initial begin
    int len, n_rand;
    acc_cnt = 0; acc_sum = 0; acc_sq = 0; acc_min = 0; acc_max = 0; acc_ovf = 0;
    add_row_end(0);
    add_sample(16'sh8000); add_row_end(0);
    add_sample(16'sh7fff); add_row_end(0);
    add_sample(16'sh7fff); add_sample(16'sh8000); add_sample(-1); add_sample(0);
    add_row_end(0);
    add_sample(-3); add_sample(-3); add_sample(-4); add_row_end(0);
    add_sample(5); add_sample(7); add_sample(-2); add_row_end(1);
    add_row_end(0);
    n_rand = pending_q.size();
    while (n_rand < 1850) begin
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
      for (int i = 0; i < len; i++) add_sample(pick_sample());
      add_row_end($urandom_range(0, 40) == 0);
      n_rand += len + 1;
    end
    n_total = pending_q.size();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (row_stats_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (n_fail == 0 && row_stats_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
